// File: rtl/pls_pkg.sv
`default_nettype none

package pls_pkg;

  localparam int COORD_W   = 4;
  localparam int COORD_N   = 2 ** COORD_W;
  localparam int VAL_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int DIFF_W    = VAL_W + 2;
  localparam int HALF_W    = FRAC_W + 1;
  localparam int PROD_W    = DIFF_W + HALF_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int RND_W     = ACC_W - FRAC_W;
  localparam int SUM_W     = ACC_W + 1;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_Z = 2'd2;

  localparam logic [VAL_W-1:0] WEIGHT_RESET = 32'h0001_0000;
  localparam logic signed [VAL_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] SAT_MIN = 32'sh8000_0000;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  typedef struct packed {
    logic                    kind;
    logic [COORD_W-1:0]      cell_x;
    logic [COORD_W-1:0]      cell_y;
    logic [COORD_W-1:0]      cell_z;
    logic signed [VAL_W-1:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] operator_value;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] wx;
    logic [VAL_W-1:0] wy;
    logic [VAL_W-1:0] wz;
  } weights_t;

  typedef enum logic [2:0] {
    NB_C  = 3'd0,
    NB_XP = 3'd1,
    NB_XM = 3'd2,
    NB_YP = 3'd3,
    NB_YM = 3'd4,
    NB_ZP = 3'd5,
    NB_ZM = 3'd6
  } nb_e;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } ax_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_WRITE = 3'd1,
    ST_READ  = 3'd2,
    ST_WAIT  = 3'd3,
    ST_OUT   = 3'd4
  } state_e;

  typedef struct packed {
    logic latch;
    logic mem_we;
    logic rd_en;
    nb_e  rd_sel;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic res_done;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/pls_regs.sv
`default_nettype none

module pls_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pls_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [pls_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic      [pls_pkg::CFG_DATA_W-1:0]      prdata,
  output pls_pkg::weights_t                        weights_o
);

  pls_pkg::weights_t w_q, w_d;
  logic [pls_pkg::REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx   = paddr[pls_pkg::CFG_ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    w_d = w_q;
    if (wr_en) begin
      case (idx)
        pls_pkg::REG_WEIGHT_X: w_d.wx = pwdata;
        pls_pkg::REG_WEIGHT_Y: w_d.wy = pwdata;
        pls_pkg::REG_WEIGHT_Z: w_d.wz = pwdata;
        default: w_d = w_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pls_pkg::REG_WEIGHT_X: prdata = w_q.wx;
      pls_pkg::REG_WEIGHT_Y: prdata = w_q.wy;
      pls_pkg::REG_WEIGHT_Z: prdata = w_q.wz;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q.wx <= pls_pkg::WEIGHT_RESET;
      w_q.wy <= pls_pkg::WEIGHT_RESET;
      w_q.wz <= pls_pkg::WEIGHT_RESET;
    end else begin
      w_q <= w_d;
    end
  end

  assign weights_o = w_q;

endmodule

`default_nettype wire

// File: rtl/pls_ctrl.sv
`default_nettype none

module pls_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_kind_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pls_pkg::dp_cmd_t        cmd_o,
  input  wire pls_pkg::dp_status_t status_i
);

  pls_pkg::state_e state_q, state_d;
  pls_pkg::nb_e    nb_q, nb_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;
  logic            load;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    nb_d       = nb_q;
    in_stall_o = 1'b1;
    load       = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel = pls_pkg::NB_C;
    case (state_q)
      pls_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          nb_d        = pls_pkg::NB_C;
          state_d     = (in_kind_i == pls_pkg::KIND_QUERY) ? pls_pkg::ST_READ
                                                           : pls_pkg::ST_WRITE;
        end
      end
      pls_pkg::ST_WRITE: begin
        cmd_o.mem_we = 1'b1;
        state_d      = pls_pkg::ST_IDLE;
      end
      pls_pkg::ST_READ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = nb_q;
        if (nb_q == pls_pkg::NB_ZM) begin
          state_d = pls_pkg::ST_WAIT;
        end else begin
          nb_d = pls_pkg::nb_e'(nb_q + 3'd1);
        end
      end
      pls_pkg::ST_WAIT: begin
        if (status_i.res_done) begin
          if (slot_free) begin
            load    = 1'b1;
            state_d = pls_pkg::ST_IDLE;
          end else begin
            state_d = pls_pkg::ST_OUT;
          end
        end
      end
      pls_pkg::ST_OUT: begin
        if (slot_free) begin
          load    = 1'b1;
          state_d = pls_pkg::ST_IDLE;
        end
      end
      default: state_d = pls_pkg::ST_IDLE;
    endcase
    cmd_o.load_out = load;
    out_valid_d    = (out_valid_q && out_stall_i) || load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pls_pkg::ST_IDLE;
      nb_q        <= pls_pkg::NB_C;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nb_q        <= nb_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/pls_dp.sv
`default_nettype none

module pls_dp #(
  parameter int GRID_X = 16,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pls_pkg::dp_cmd_t  cmd_i,
  output pls_pkg::dp_status_t    status_o,
  input  wire pls_pkg::in_item_t in_item_i,
  input  wire pls_pkg::weights_t weights_i,
  output pls_pkg::out_item_t     out_item_o
);

  localparam int XW     = $clog2(GRID_X);
  localparam int YW     = $clog2(GRID_Y);
  localparam int ZW     = $clog2(GRID_Z);
  localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = pls_pkg::COORD_W;
  localparam int VW     = pls_pkg::VAL_W;
  localparam int FW     = pls_pkg::FRAC_W;
  localparam int DW     = pls_pkg::DIFF_W;
  localparam int PW     = pls_pkg::PROD_W;
  localparam int ACW    = pls_pkg::ACC_W;
  localparam int RW     = pls_pkg::RND_W;
  localparam int SW     = pls_pkg::SUM_W;
  localparam logic [XW-1:0] X_LAST = XW'(GRID_X - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(GRID_Y - 1);
  localparam logic [ZW-1:0] Z_LAST = ZW'(GRID_Z - 1);
  localparam logic [AW-1:0] GX_A   = AW'(GRID_X);
  localparam logic [AW-1:0] GY_A   = AW'(GRID_Y);

  // coordinate latch
  logic [XW-1:0] x_mod, x_q, nx;
  logic [YW-1:0] y_mod, y_q, ny;
  logic [ZW-1:0] z_mod, z_q, nz;
  logic signed [VW-1:0] val_q;
  logic pin_q;

  always_comb begin
    x_mod = '0;
    y_mod = '0;
    z_mod = '0;
    for (int i = 0; i < pls_pkg::COORD_N; i++) begin
      if (in_item_i.cell_x == CW'(i)) x_mod = XW'(i % GRID_X);
      if (in_item_i.cell_y == CW'(i)) y_mod = YW'(i % GRID_Y);
      if (in_item_i.cell_z == CW'(i)) z_mod = ZW'(i % GRID_Z);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      x_q   <= x_mod;
      y_q   <= y_mod;
      z_q   <= z_mod;
      val_q <= in_item_i.cell_value;
      pin_q <= (x_mod == '0) && (y_mod == '0) && (z_mod == '0);
    end
  end

  // periodic neighbor address
  logic [AW-1:0] addr;

  always_comb begin
    nx = x_q;
    ny = y_q;
    nz = z_q;
    case (cmd_i.rd_sel)
      pls_pkg::NB_XP: nx = (x_q == X_LAST) ? '0 : x_q + 1'b1;
      pls_pkg::NB_XM: nx = (x_q == '0) ? X_LAST : x_q - 1'b1;
      pls_pkg::NB_YP: ny = (y_q == Y_LAST) ? '0 : y_q + 1'b1;
      pls_pkg::NB_YM: ny = (y_q == '0) ? Y_LAST : y_q - 1'b1;
      pls_pkg::NB_ZP: nz = (z_q == Z_LAST) ? '0 : z_q + 1'b1;
      pls_pkg::NB_ZM: nz = (z_q == '0) ? Z_LAST : z_q - 1'b1;
      default: nx = x_q;
    endcase
    addr = AW'(nx) + GX_A * (AW'(ny) + GY_A * AW'(nz));
  end

  // cell memory, single port
  logic [VW-1:0] cell_mem_q [CELLS];
  logic signed [VW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      cell_mem_q[addr] <= val_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= $signed(cell_mem_q[addr]);
    end
  end

  // axis differences
  pls_pkg::nb_e rd_tag_q;
  logic rd_v_q;
  logic signed [VW-1:0] c_q;
  logic signed [DW-1:0] d_q, df_q, two_c, rd_ext, d_first, d_last;
  logic df_v_q;
  pls_pkg::ax_e df_ax_q;

  assign two_c   = $signed({c_q[VW-1], c_q, 1'b0});
  assign rd_ext  = DW'(rd_data_q);
  assign d_first = two_c - rd_ext;
  assign d_last  = d_q - rd_ext;

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      case (rd_tag_q)
        pls_pkg::NB_C: c_q <= rd_data_q;
        pls_pkg::NB_XP, pls_pkg::NB_YP, pls_pkg::NB_ZP: d_q <= d_first;
        pls_pkg::NB_XM, pls_pkg::NB_YM, pls_pkg::NB_ZM: df_q <= d_last;
        default: d_q <= d_q;
      endcase
    end
  end

  // weighted products, weight split in integer and fraction halves
  logic [VW-1:0] w_sel;
  logic signed [PW-1:0] df_ext, wh_ext, wl_ext, ph_q, pl_q;
  logic pm_v_q;
  pls_pkg::ax_e pm_ax_q;

  always_comb begin
    case (df_ax_q)
      pls_pkg::AX_X: w_sel = weights_i.wx;
      pls_pkg::AX_Y: w_sel = weights_i.wy;
      pls_pkg::AX_Z: w_sel = weights_i.wz;
      default: w_sel = weights_i.wx;
    endcase
  end

  assign df_ext = PW'(df_q);
  assign wh_ext = PW'({1'b0, w_sel[VW-1:FW]});
  assign wl_ext = PW'({1'b0, w_sel[FW-1:0]});

  always_ff @(posedge clk_i) begin
    if (df_v_q) begin
      ph_q <= df_ext * wh_ext;
      pl_q <= df_ext * wl_ext;
    end
  end

  // accumulate, round, saturate
  logic signed [ACW-1:0] hi_acc_q, lo_acc_q;
  logic [ACW-1:0] lo_round;
  logic signed [RW-1:0] rnd_q;
  logic signed [SW-1:0] sum;
  logic acc_v_q, rv_q, res_done_q;
  logic signed [VW-1:0] res_val_q;
  logic res_sat_q;
  pls_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      hi_acc_q <= '0;
      lo_acc_q <= '0;
    end else if (pm_v_q) begin
      hi_acc_q <= hi_acc_q + ACW'(ph_q);
      lo_acc_q <= lo_acc_q + ACW'(pl_q);
    end
  end

  assign lo_round = lo_acc_q + pls_pkg::ROUND_HALF;

  always_ff @(posedge clk_i) begin
    if (acc_v_q) begin
      rnd_q <= $signed(lo_round[ACW-1:FW]);
    end
  end

  assign sum = SW'(hi_acc_q) + SW'(rnd_q);

  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      if (pin_q) begin
        res_val_q <= c_q;
        res_sat_q <= 1'b0;
      end else if (sum > SW'(pls_pkg::SAT_MAX)) begin
        res_val_q <= pls_pkg::SAT_MAX;
        res_sat_q <= 1'b1;
      end else if (sum < SW'(pls_pkg::SAT_MIN)) begin
        res_val_q <= pls_pkg::SAT_MIN;
        res_sat_q <= 1'b1;
      end else begin
        res_val_q <= sum[VW-1:0];
        res_sat_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.operator_value <= res_val_q;
      out_q.saturated      <= res_sat_q;
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q     <= 1'b0;
      rd_tag_q   <= pls_pkg::NB_C;
      df_v_q     <= 1'b0;
      df_ax_q    <= pls_pkg::AX_X;
      pm_v_q     <= 1'b0;
      pm_ax_q    <= pls_pkg::AX_X;
      acc_v_q    <= 1'b0;
      rv_q       <= 1'b0;
      res_done_q <= 1'b0;
    end else begin
      rd_v_q     <= cmd_i.rd_en;
      rd_tag_q   <= cmd_i.rd_sel;
      df_v_q     <= rd_v_q && ((rd_tag_q == pls_pkg::NB_XM) ||
                               (rd_tag_q == pls_pkg::NB_YM) ||
                               (rd_tag_q == pls_pkg::NB_ZM));
      if (rd_tag_q == pls_pkg::NB_XM) begin
        df_ax_q <= pls_pkg::AX_X;
      end else if (rd_tag_q == pls_pkg::NB_YM) begin
        df_ax_q <= pls_pkg::AX_Y;
      end else begin
        df_ax_q <= pls_pkg::AX_Z;
      end
      pm_v_q     <= df_v_q;
      pm_ax_q    <= df_ax_q;
      acc_v_q    <= pm_v_q && (pm_ax_q == pls_pkg::AX_Z);
      rv_q       <= acc_v_q;
      res_done_q <= rv_q;
    end
  end

  assign status_o.res_done = res_done_q;
  assign out_item_o        = out_q;

endmodule

`default_nettype wire

// File: rtl/periodic_laplacian_stencil_core.sv
`default_nettype none
// query: result valid once the seven reads have passed the difference, product, accumulate, round and
// saturate registers and a free output slot takes it; the next item is taken in the cycle the result goes valid
// write: latched in idle, stored in the write state, no result; query rate set by the seven reads of the
// single-port cell memory, one per cycle, then the pipeline stages, and held while the output is stalled
// reset: control and output valid clear, weights return to 1.0, grid undefined until written

module periodic_laplacian_stencil_core #(
  parameter int GRID_X = 16,
  parameter int GRID_Y = 16,
  parameter int GRID_Z = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire pls_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output pls_pkg::out_item_t                  out_item_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pls_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [pls_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [pls_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);

  pls_pkg::weights_t   weights;
  pls_pkg::dp_cmd_t    cmd;
  pls_pkg::dp_status_t status;

  assign pready = 1'b1;

  pls_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .weights_o (weights)
  );

  pls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_item_i.kind),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  pls_dp #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_item_i  (in_item_i),
    .weights_i  (weights),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// File: rtl/pls_checker.sv
`default_nettype none

module pls_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire pls_pkg::out_item_t out_item_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // a new result leaves the block ready for the next item
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result raised while still busy");

  // clipping flag only on a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.saturated |->
      (out_item_o.operator_value == pls_pkg::SAT_MAX) ||
      (out_item_o.operator_value == pls_pkg::SAT_MIN))
    else $error("saturated set on an unclipped value");

endmodule

bind periodic_laplacian_stencil_core pls_checker u_pls_checker (.*);

`default_nettype wire
